### rtl/srec_pkg.sv
`timescale 1ns / 1ps

package srec_pkg;

	localparam logic [7:0] DATA_OVERHEAD = 8'd5;
	localparam logic [7:0] BOOT_POS      = 8'd11;
	localparam logic [7:0] APP_POS       = 8'd13;
	localparam logic [3:0] KIND_S0       = 4'd0;
	localparam logic [3:0] KIND_S3       = 4'd3;
	localparam logic [3:0] KIND_S7       = 4'd7;
	localparam logic [3:0] KIND_NONDIGIT = 4'd15;
	localparam logic [7:0] ALIGN_RESET   = 8'd31;
	localparam logic [7:0] SUM_BASE      = 8'hFF;

	typedef enum logic [1:0] {
		PH_IDLE = 2'b01,
		PH_RUN  = 2'b10
	} phase_t;

	typedef struct packed {
		logic       bad;
		logic [3:0] nib;
	} hex_dec_t;

	function automatic hex_dec_t hex_decode(input logic [7:0] c);
		hex_dec_t r;
		r.bad = 1'b0;
		r.nib = 4'd0;
		case (c) inside
			[8'h30:8'h39]: r.nib = c[3:0];
			[8'h41:8'h46],
			[8'h61:8'h66]: r.nib = 4'(c[2:0] + 3'd1) + 4'd8;
			default: r.bad = 1'b1;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] type_digit(input logic [7:0] c);
		logic [3:0] r;
		case (c) inside
			[8'h30:8'h39]: r = c[3:0];
			default: r = KIND_NONDIGIT;
		endcase
		return r;
	endfunction

endpackage

### rtl/srecord_hex_record_decoder_core.sv
`timescale 1ns / 1ps
// throughput: one character per cycle while the output is not stalled by out_ready;
// the input register feeds one decode step into the output register
// a full output register still lets the input stage take a word while the output is taken
// reset (arst_n low, asynchronous): idle waiting for a start digit, counters and sums zero,
// align_mask back to 31, no output word pending

module srecord_hex_record_decoder_core
	import srec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	input  logic        start_req,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic [7:0]  byte_index,
	output logic [3:0]  record_type,
	output logic [31:0] address,
	output logic [7:0]  data_length,
	output logic        checksum_ok,
	output logic        misaligned,
	output logic [15:0] boot_version,
	output logic [15:0] app_version,
	output logic        bad_char,
	output logic        last
);

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       start_s1;

	// record state
	phase_t      phase_q;
	logic [7:0]  align_mask_q;
	logic [3:0]  high_nibble_q;
	logic        nibble_odd_q;
	logic [7:0]  byte_count_q;
	logic [7:0]  record_length_q;
	logic [3:0]  record_kind_q;
	logic [31:0] address_acc_q;
	logic [7:0]  byte_sum_q;
	logic [15:0] boot_ver_acc_q;
	logic [15:0] app_ver_acc_q;
	logic        bad_seen_q;

	// output register
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  data_byte_q;
	logic [7:0]  byte_index_q;
	logic [3:0]  record_type_q;
	logic [31:0] address_q;
	logic [7:0]  data_length_q;
	logic        checksum_ok_q;
	logic        misaligned_q;
	logic [15:0] boot_version_q;
	logic [15:0] app_version_q;
	logic        bad_char_q;

	logic        adv;
	logic        proc;
	logic        run;
	hex_dec_t    dec;
	logic [7:0]  b;
	logic [7:0]  p;
	logic [7:0]  len_n;
	logic [31:0] addr_n;
	logic [15:0] boot_n;
	logic [15:0] app_n;
	logic        addr_kind;
	logic        byte_done;
	logic        is_sum;
	logic        is_data;
	logic        res_valid;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;
	assign proc      = valid_s1 && adv;
	assign run       = (phase_q == PH_RUN) && !start_s1;

	always_comb begin
		dec       = hex_decode(char_s1);
		b         = {high_nibble_q, dec.nib};
		p         = byte_count_q;
		len_n     = (p == 8'd0) ? b : record_length_q;
		addr_kind = (record_kind_q == KIND_S3) || (record_kind_q == KIND_S7);
		addr_n    = address_acc_q;
		if (addr_kind && p >= 8'd1 && p <= 8'd4) begin
			addr_n = {address_acc_q[23:0], b};
		end
		boot_n = boot_ver_acc_q;
		app_n  = app_ver_acc_q;
		if (record_kind_q == KIND_S0) begin
			if (p == BOOT_POS || p == BOOT_POS + 8'd1) begin
				boot_n = {boot_ver_acc_q[7:0], b};
			end
			if (p == APP_POS || p == APP_POS + 8'd1) begin
				app_n = {app_ver_acc_q[7:0], b};
			end
		end
		byte_done = run && nibble_odd_q;
		is_sum    = byte_done && (p == len_n);
		is_data   = byte_done && !is_sum && (record_kind_q == KIND_S3) && (p >= DATA_OVERHEAD);
		res_valid = proc && (is_sum || is_data);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1  <= char_in;
			start_s1 <= start_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_mask_q <= ALIGN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			align_mask_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			high_nibble_q   <= '0;
			nibble_odd_q    <= 1'b0;
			byte_count_q    <= '0;
			record_length_q <= '0;
			record_kind_q   <= '0;
			address_acc_q   <= '0;
			byte_sum_q      <= '0;
			boot_ver_acc_q  <= '0;
			app_ver_acc_q   <= '0;
			bad_seen_q      <= 1'b0;
		end else if (proc) begin
			if (start_s1) begin
				phase_q         <= PH_RUN;
				record_kind_q   <= type_digit(char_s1);
				high_nibble_q   <= '0;
				nibble_odd_q    <= 1'b0;
				byte_count_q    <= '0;
				record_length_q <= '0;
				address_acc_q   <= '0;
				byte_sum_q      <= '0;
				boot_ver_acc_q  <= '0;
				app_ver_acc_q   <= '0;
				bad_seen_q      <= 1'b0;
			end else if (run) begin
				if (dec.bad) begin
					bad_seen_q <= 1'b1;
				end
				if (!nibble_odd_q) begin
					high_nibble_q <= dec.nib;
					nibble_odd_q  <= 1'b1;
				end else begin
					nibble_odd_q    <= 1'b0;
					record_length_q <= len_n;
					address_acc_q   <= addr_n;
					boot_ver_acc_q  <= boot_n;
					app_ver_acc_q   <= app_n;
					if (is_sum) begin
						phase_q <= PH_IDLE;
					end else begin
						byte_sum_q   <= byte_sum_q + b;
						byte_count_q <= p + 8'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			kind_q         <= is_sum;
			data_byte_q    <= is_sum ? 8'd0 : b;
			byte_index_q   <= is_sum ? 8'd0 : p - DATA_OVERHEAD;
			record_type_q  <= is_sum ? record_kind_q : 4'd0;
			address_q      <= (is_sum && addr_kind) ? addr_n : 32'd0;
			data_length_q  <= (is_sum && len_n >= DATA_OVERHEAD) ? len_n - DATA_OVERHEAD : 8'd0;
			// checksum byte is compared against the ones complement of the byte sum
			checksum_ok_q  <= is_sum && ((SUM_BASE - byte_sum_q) == b);
			misaligned_q   <= is_sum && (record_kind_q == KIND_S3)
				&& ((addr_n[7:0] & align_mask_q) != 8'd0);
			boot_version_q <= (is_sum && record_kind_q == KIND_S0) ? boot_n : 16'd0;
			app_version_q  <= (is_sum && record_kind_q == KIND_S0) ? app_n : 16'd0;
			bad_char_q     <= is_sum && (bad_seen_q || dec.bad);
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign data_byte    = data_byte_q;
	assign byte_index   = byte_index_q;
	assign record_type  = record_type_q;
	assign address      = address_q;
	assign data_length  = data_length_q;
	assign checksum_ok  = checksum_ok_q;
	assign misaligned   = misaligned_q;
	assign boot_version = boot_version_q;
	assign app_version  = app_version_q;
	assign bad_char     = bad_char_q;
	assign last         = kind_q;

`ifndef SYNTHESIS
	a_sum_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && is_sum) |=> (phase_q == PH_IDLE))
		else $error("summary word did not end the record");

	a_odd_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		nibble_odd_q |-> (phase_q == PH_RUN))
		else $error("half byte pending while idle");

	a_data_only_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && is_data) |-> (record_kind_q == KIND_S3 && byte_count_q >= DATA_OVERHEAD))
		else $error("data word outside an s3 data field");

	a_stall_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> ($stable(byte_count_q) && $stable(nibble_odd_q)))
		else $error("record state moved while output stalled");
`endif

endmodule
